[rtl/core/dqi_pkg.sv]
`default_nettype none

package dqi_pkg;

	// Fixed field widths of the stream payload
	localparam int MODE_W  = 3;
	localparam int POS_W   = 5;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	// Packed stream widths, padded to whole bytes
	localparam int IN_BITS  = MODE_W + POS_W + DATA_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * DATA_W + COUNT_W + 2;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Operation codes carried in the mode field
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;

	// Command broadcast along a row of cells
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT
	} cell_op_t;

endpackage

`default_nettype wire

[rtl/core/dqi_cell.sv]
`default_nettype none

module dqi_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire                                clk,
	input  wire  dqi_pkg::cell_op_t            op,
	input  wire  [CW-1:0]                      pos,
	input  wire  [dqi_pkg::DATA_W-1:0]         load_value,
	input  wire  [dqi_pkg::DATA_W-1:0]         left_data,
	input  wire  [dqi_pkg::DATA_W-1:0]         right_data,
	output logic [dqi_pkg::DATA_W-1:0]         data
);
	import dqi_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_next;

	// Insert: load at the target slot, take from the left beyond it, hold before it.
	// Shift: take from the right, closing the gap at slot zero.
	always_comb begin
		data_next = data_q;
		case (op)
			OP_INSERT: begin
				if (IDX_C == pos) begin
					data_next = load_value;
				end else if (IDX_C > pos) begin
					data_next = left_data;
				end
			end
			OP_SHIFT: begin
				data_next = right_data;
			end
			default: begin
				data_next = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

	assign data = data_q;

endmodule

`default_nettype wire

[rtl/core/dqi_chain.sv]
`default_nettype none

module dqi_chain #(
	parameter int DEPTH = 16
) (
	input  wire                                   clk,
	input  wire  dqi_pkg::cell_op_t               op,
	input  wire  [$clog2(DEPTH+1)-1:0]            pos,
	input  wire  [dqi_pkg::DATA_W-1:0]            load_value,
	output logic [dqi_pkg::DATA_W-1:0]            head
);
	import dqi_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] cell_data  [DEPTH];
	logic [DATA_W-1:0] left_data  [DEPTH];
	logic [DATA_W-1:0] right_data [DEPTH];

	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		// Missing neighbors tie to the load word; the first cell never selects its one, the last shifts it in
		if (gi == 0) begin : g_first
			assign left_data[gi] = load_value;
		end else begin : g_mid_l
			assign left_data[gi] = cell_data[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_last
			assign right_data[gi] = load_value;
		end else begin : g_mid_r
			assign right_data[gi] = cell_data[gi+1];
		end

		dqi_cell #(
			.IDX (gi),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.pos        (pos),
			.load_value (load_value),
			.left_data  (left_data[gi]),
			.right_data (right_data[gi]),
			.data       (cell_data[gi])
		);
	end

	assign head = cell_data[0];

endmodule

`default_nettype wire

[rtl/core/deque_with_indexed_insert.sv]
`default_nettype none

// Bounded deque of signed 32-bit words with push front, push back, insert at
// a position, pop front and pop back. One command beat in, one status beat out:
// each result carries the front and back words (0 when empty), the entry count,
// an empty flag and a dropped flag for a push or insert refused on a full store.
// The block takes one beat per clock cycle while results are taken; the result
// appears the cycle after the command beat, and the next command is taken in
// that same cycle when the result is taken too. The rows of cells shift or
// insert all entries at once. Two rows are kept: one in front-first
// order and one in back-first order, so both ends are read from slot zero.
// Entries hold no reset; only the count and the output valid flag are cleared.

module deque_with_indexed_insert #(
	parameter int DEPTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// [2:0] mode, [7:3] position, [39:8] value
	input  wire  [dqi_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// [31:0] front_value, [63:32] back_value, [68:64] entry_count,
	// [69] is_empty, [70] dropped, [71] zero
	output logic [dqi_pkg::OUT_W-1:0]    m_tdata
);
	import dqi_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

	logic              fire;
	logic [MODE_W-1:0] mode_in;
	logic [POS_W-1:0]  pos_in;
	logic [DATA_W-1:0] value_in;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_next;
	logic              out_valid_q;
	logic              dropped_q;
	logic              drop;

	logic              full;
	logic              empty;
	logic [PW-1:0]     pos_ext;
	logic [PW-1:0]     cnt_ext;
	logic [CW-1:0]     pos_clip;
	logic [CW-1:0]     ins_pos;

	cell_op_t          op_fwd;
	cell_op_t          op_rev;
	logic [CW-1:0]     pos_fwd;
	logic [CW-1:0]     pos_rev;
	logic [DATA_W-1:0] head_fwd;
	logic [DATA_W-1:0] head_rev;

	logic [DATA_W-1:0] front_value;
	logic [DATA_W-1:0] back_value;

	assign mode_in  = s_tdata[MODE_W-1:0];
	assign pos_in   = s_tdata[MODE_W+POS_W-1:MODE_W];
	assign value_in = s_tdata[MODE_W+POS_W+DATA_W-1:MODE_W+POS_W];

	// Hold new commands while a result waits untaken
	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	assign full  = (count_q == FULL_C);
	assign empty = (count_q == '0);

	// Clip the insert position: anything at or past the count appends at the back
	assign pos_ext  = PW'(pos_in);
	assign cnt_ext  = PW'(count_q);
	assign pos_clip = (pos_ext >= cnt_ext) ? count_q : pos_ext[CW-1:0];

	// Decode one command into a broadcast for each row. The back-first row sees
	// an insert at slot p as an insert at count - p.
	always_comb begin
		op_fwd     = OP_HOLD;
		op_rev     = OP_HOLD;
		pos_fwd    = '0;
		pos_rev    = '0;
		ins_pos    = '0;
		count_next = count_q;
		drop       = 1'b0;
		if (fire) begin
			case (mode_in)
				MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
					if (full) begin
						drop = 1'b1;
					end else begin
						if (mode_in == MODE_PUSH_FRONT) begin
							ins_pos = '0;
						end else if (mode_in == MODE_PUSH_BACK) begin
							ins_pos = count_q;
						end else begin
							ins_pos = pos_clip;
						end
						op_fwd     = OP_INSERT;
						pos_fwd    = ins_pos;
						op_rev     = OP_INSERT;
						pos_rev    = count_q - ins_pos;
						count_next = count_q + CW'(1);
					end
				end
				MODE_POP_FRONT: begin
					if (!empty) begin
						op_fwd     = OP_SHIFT;
						count_next = count_q - CW'(1);
					end
				end
				MODE_POP_BACK: begin
					if (!empty) begin
						op_rev     = OP_SHIFT;
						count_next = count_q - CW'(1);
					end
				end
				default: begin
					// unused modes leave the store alone
				end
			endcase
		end
	end

	// Front-first row: slot zero holds the front entry
	dqi_chain #(
		.DEPTH (DEPTH)
	) u_chain_fwd (
		.clk        (clk),
		.op         (op_fwd),
		.pos        (pos_fwd),
		.load_value (value_in),
		.head       (head_fwd)
	);

	// Back-first row: slot zero holds the back entry
	dqi_chain #(
		.DEPTH (DEPTH)
	) u_chain_rev (
		.clk        (clk),
		.op         (op_rev),
		.pos        (pos_rev),
		.load_value (value_in),
		.head       (head_rev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dropped_q <= drop;
		end
	end

	// The result reads straight from the rows; state holds while it waits
	assign front_value = empty ? '0 : head_fwd;
	assign back_value  = empty ? '0 : head_rev;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, dropped_q, empty,
		COUNT_W'(count_q), back_value, front_value};

	// The count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("entry count beyond depth");

	// A push or insert into a full store yields a dropped result
	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && full && (mode_in == MODE_PUSH_FRONT || mode_in == MODE_PUSH_BACK
			|| mode_in == MODE_INSERT)) |=> (m_tvalid && dropped_q))
		else $error("full store push not flagged as dropped");

	// The store does not move while a result is stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(count_q))
		else $error("count changed under a stalled result");

	// With a single entry both rows must agree on it
	a_single_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(1)) |-> (head_fwd == head_rev))
		else $error("front and back rows disagree on the only entry");

endmodule

`default_nettype wire
